// ===== design/sorted_event_timer_queue_top_macros.svh =====
// Assertion macros shared by the checker of the sorted event timer queue.
`ifndef SORTED_EVENT_TIMER_QUEUE_TOP_MACROS_SVH
`define SORTED_EVENT_TIMER_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SETQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SETQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/setq_pkg.sv =====
// Types, codes and field layout shared by the sorted event timer queue.
`timescale 1ns / 1ps
package setq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 48;
   localparam int DEV_BITS    = 6;
   localparam int TAG_BITS    = 16;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam int OP_BITS   = 3;
   localparam int KIND_BITS = 2;
   localparam int ERR_BITS  = 2;

   localparam logic [OP_BITS-1:0] OP_INSERT     = 3'd0;
   localparam logic [OP_BITS-1:0] OP_REMOVE_ONE = 3'd1;
   localparam logic [OP_BITS-1:0] OP_REMOVE_ALL = 3'd2;
   localparam logic [OP_BITS-1:0] OP_PENDING    = 3'd3;
   localparam logic [OP_BITS-1:0] OP_LIST       = 3'd4;
   localparam logic [OP_BITS-1:0] OP_RUN        = 3'd5;

   localparam logic [KIND_BITS-1:0] KIND_FIRED  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_LISTED = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_STATUS = 2'd2;

   localparam logic [ERR_BITS-1:0] ERR_OK   = 2'd0;
   localparam logic [ERR_BITS-1:0] ERR_FULL = 2'd1;
   localparam logic [ERR_BITS-1:0] ERR_LATE = 2'd2;

   localparam logic [2:0] CMD_HOLD   = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_REMOVE = 3'd2;
   localparam logic [2:0] CMD_SHIFT  = 3'd3;
   localparam logic [2:0] CMD_ROTATE = 3'd4;

   // Request beat: time, device, tag from bit 0 up, padded to whole bytes.
   localparam int REQ_FIELD_BITS = TIME_BITS + DEV_BITS + TAG_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;

   // Response beat: time, device, tag, found, error, next time, empty.
   localparam int RSP_TIME_LSB  = 0;
   localparam int RSP_DEV_LSB   = RSP_TIME_LSB + TIME_BITS;
   localparam int RSP_TAG_LSB   = RSP_DEV_LSB + DEV_BITS;
   localparam int RSP_FOUND_LSB = RSP_TAG_LSB + TAG_BITS;
   localparam int RSP_ERR_LSB   = RSP_FOUND_LSB + 1;
   localparam int RSP_NEXT_LSB  = RSP_ERR_LSB + ERR_BITS;
   localparam int RSP_EMPTY_LSB = RSP_NEXT_LSB + TIME_BITS;
   localparam int RSP_FIELD_BITS = RSP_EMPTY_LSB + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - RSP_FIELD_BITS;

   typedef struct packed {
      logic [TIME_BITS-1:0] time_val;
      logic [DEV_BITS-1:0]  device;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic [2:0] cmd;
      entry_type  key;
      logic       dev_only;
   } cell_ctrl_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      entry_type            ent;
      logic                 found;
      logic [ERR_BITS-1:0]  error;
      logic [TIME_BITS-1:0] next_time;
      logic                 queue_empty;
      logic                 last;
   } rsp_type;

endpackage

// ===== design/setq_cell.sv =====
// One slot of the ordered event chain: holds an entry and moves it to or from its neighbors.
`timescale 1ns / 1ps
module setq_cell
   import setq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  logic          tail,
   input  logic          prev_keep,
   input  logic          prev_hit,
   input  entry_type     prev_entry,
   input  entry_type     next_entry,
   input  entry_type     head_entry,
   output entry_type     entry,
   output logic          keep,
   output logic          hit
);

   entry_type entry_ff, entry_in;
   logic      match;

   assign match = occupied && (entry_ff.device == ctrl.key.device)
                  && (ctrl.dev_only || (entry_ff.tag == ctrl.key.tag));
   assign keep  = occupied && (entry_ff.time_val <= ctrl.key.time_val);
   assign hit   = prev_hit || match;
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.cmd)
         CMD_HOLD: begin
            entry_in = entry_ff;
         end
         CMD_INSERT: begin
            if (!keep) begin
               entry_in = prev_keep ? ctrl.key : prev_entry;
            end
         end
         CMD_REMOVE: begin
            if (hit) begin
               entry_in = next_entry;
            end
         end
         CMD_SHIFT: begin
            entry_in = next_entry;
         end
         CMD_ROTATE: begin
            entry_in = tail ? head_entry : next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== design/sorted_event_timer_queue_top.sv =====
// Top level of the sorted event timer queue: control sequencer, cell chain and response register.
//
//   channel   ports        direction   payload
//   request   req_t*       in          op in tuser, time/device/tag in tdata
//   response  rsp_t*       out         kind in tuser, status fields in tdata, last in tlast
//
// Insert, remove-one, pending and unused ops go from the accepted beat through the op and
// status states to the status beat. Remove-all drops one entry per step, run-to-limit fires
// one event per step, and list rotates the chain once through all entries. The chain moves
// one step per cycle unless a stalled response holds a step that must emit a beat.
// Reset is synchronous and clears the count, current time, sequencer and response valid.
// A stalled response stalls only steps that must emit a beat; a new request is taken
// while the status beat still waits.
`timescale 1ns / 1ps
module sorted_event_timer_queue_top
   import setq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // time, device_id, user_tag, zero pad
   input  logic [OP_BITS-1:0]       req_tuser,  // op
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // out_time, out_device, out_tag, found,
                                                // error, next_time, queue_empty, zero pad
   output logic [KIND_BITS-1:0]     rsp_tuser,  // kind
   output logic                     rsp_tlast
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_OP     = 2'd1;
   localparam logic [1:0] ST_LIST   = 2'd2;
   localparam logic [1:0] ST_STATUS = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [OP_BITS-1:0]    op_ff, op_in;
   entry_type             key_ff, key_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] rot_ff, rot_in;
   logic [TIME_BITS-1:0]  cur_time_ff, cur_time_in;
   logic                  found_ff, found_in;
   logic [ERR_BITS-1:0]   err_ff, err_in;
   logic [TIME_BITS-1:0]  list_next_ff, list_next_in;
   logic                  list_empty_ff, list_empty_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   cell_ctrl_type         ctrl;
   entry_type             cell_entry [QUEUE_DEPTH];
   logic                  cell_keep  [QUEUE_DEPTH];
   logic                  cell_hit   [QUEUE_DEPTH];
   logic                  load_rsp;
   logic                  out_free;
   logic [TIME_BITS-1:0]  status_next;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign status_next = (count_ff == '0) ? '0 : cell_entry[0].time_val;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic      occ;
      logic      tl;
      logic      pk;
      logic      ph;
      entry_type pe;
      entry_type ne;

      assign occ = COUNT_BITS'(i) < count_ff;
      assign tl  = COUNT_BITS'(i + 1) == count_ff;
      if (i == 0) begin : g_first
         assign pk = 1'b1;
         assign ph = 1'b0;
         assign pe = ctrl.key;
      end else begin : g_inner
         assign pk = cell_keep[i-1];
         assign ph = cell_hit[i-1];
         assign pe = cell_entry[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign ne = cell_entry[i];
      end else begin : g_body
         assign ne = cell_entry[i+1];
      end

      setq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occ),
         .tail       (tl),
         .prev_keep  (pk),
         .prev_hit   (ph),
         .prev_entry (pe),
         .next_entry (ne),
         .head_entry (cell_entry[0]),
         .entry      (cell_entry[i]),
         .keep       (cell_keep[i]),
         .hit        (cell_hit[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      rot_in        = rot_ff;
      cur_time_in   = cur_time_ff;
      found_in      = found_ff;
      err_in        = err_ff;
      list_next_in  = list_next_ff;
      list_empty_in = list_empty_ff;
      rsp_in        = rsp_ff;
      load_rsp      = 1'b0;
      ctrl.cmd      = CMD_HOLD;
      ctrl.key      = key_ff;
      ctrl.dev_only = (op_ff == OP_REMOVE_ALL) || (op_ff == OP_LIST);
      req_tready    = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in           = req_tuser;
               key_in.time_val = req_tdata[TIME_BITS-1:0];
               key_in.device   = req_tdata[TIME_BITS +: DEV_BITS];
               key_in.tag      = req_tdata[TIME_BITS + DEV_BITS +: TAG_BITS];
               found_in        = 1'b0;
               err_in          = ERR_OK;
               state_in        = ST_OP;
            end
         end
         ST_OP: begin
            unique case (op_ff)
               OP_INSERT: begin
                  if (count_ff == COUNT_BITS'(QUEUE_DEPTH)) begin
                     err_in = ERR_FULL;
                  end else if (key_ff.time_val < cur_time_ff) begin
                     err_in = ERR_LATE;
                  end else begin
                     ctrl.cmd = CMD_INSERT;
                     count_in = count_ff + COUNT_BITS'(1);
                  end
                  state_in = ST_STATUS;
               end
               OP_REMOVE_ONE: begin
                  if (cell_hit[QUEUE_DEPTH-1]) begin
                     ctrl.cmd = CMD_REMOVE;
                     count_in = count_ff - COUNT_BITS'(1);
                     found_in = 1'b1;
                  end
                  state_in = ST_STATUS;
               end
               OP_REMOVE_ALL: begin
                  if (cell_hit[QUEUE_DEPTH-1]) begin
                     ctrl.cmd = CMD_REMOVE;
                     count_in = count_ff - COUNT_BITS'(1);
                  end else begin
                     state_in = ST_STATUS;
                  end
               end
               OP_PENDING: begin
                  found_in = cell_hit[QUEUE_DEPTH-1];
                  state_in = ST_STATUS;
               end
               OP_LIST: begin
                  list_next_in  = status_next;
                  list_empty_in = (count_ff == '0);
                  rot_in        = '0;
                  state_in      = ST_LIST;
               end
               OP_RUN: begin
                  if (cell_keep[0]) begin
                     if (out_free) begin
                        ctrl.cmd           = CMD_SHIFT;
                        count_in           = count_ff - COUNT_BITS'(1);
                        cur_time_in        = cell_entry[0].time_val;
                        load_rsp           = 1'b1;
                        rsp_in.kind        = KIND_FIRED;
                        rsp_in.ent         = cell_entry[0];
                        rsp_in.found       = 1'b0;
                        rsp_in.error       = ERR_OK;
                        rsp_in.queue_empty = (count_ff == COUNT_BITS'(1));
                        rsp_in.next_time   = (count_ff == COUNT_BITS'(1)) ? '0
                                             : cell_entry[1].time_val;
                        rsp_in.last        = 1'b0;
                     end
                  end else begin
                     state_in = ST_STATUS;
                  end
               end
               default: begin
                  state_in = ST_STATUS;
               end
            endcase
         end
         ST_LIST: begin
            if (rot_ff == count_ff) begin
               state_in = ST_STATUS;
            end else if (!cell_hit[0] || out_free) begin
               ctrl.cmd = CMD_ROTATE;
               rot_in   = rot_ff + COUNT_BITS'(1);
               if (cell_hit[0]) begin
                  load_rsp           = 1'b1;
                  rsp_in.kind        = KIND_LISTED;
                  rsp_in.ent         = cell_entry[0];
                  rsp_in.found       = 1'b0;
                  rsp_in.error       = ERR_OK;
                  rsp_in.next_time   = list_next_ff;
                  rsp_in.queue_empty = list_empty_ff;
                  rsp_in.last        = 1'b0;
               end
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               load_rsp           = 1'b1;
               rsp_in.kind        = KIND_STATUS;
               rsp_in.ent         = '0;
               rsp_in.found       = found_ff;
               rsp_in.error       = err_ff;
               rsp_in.next_time   = status_next;
               rsp_in.queue_empty = (count_ff == '0);
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cur_time_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_time_ff  <= cur_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      rot_ff        <= rot_in;
      found_ff      <= found_in;
      err_ff        <= err_in;
      list_next_ff  <= list_next_in;
      list_empty_ff <= list_empty_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, rsp_ff.queue_empty, rsp_ff.next_time,
                        rsp_ff.error, rsp_ff.found, rsp_ff.ent.tag, rsp_ff.ent.device,
                        rsp_ff.ent.time_val};

endmodule

// ===== design/setq_checker.sv =====
// Port-level checks of the sorted event timer queue response stream, bound to the top level.
`timescale 1ns / 1ps
`include "sorted_event_timer_queue_top_macros.svh"
module setq_checker
   import setq_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [KIND_BITS-1:0]     rsp_tuser,
   input logic                     rsp_tlast
);

   `SETQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled response beat changed")
   `SETQ_ASSERT_IMP(a_last_is_status, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tuser == KIND_STATUS), "tlast does not mark exactly the status beat")
   `SETQ_ASSERT_IMP(a_event_no_flags, clock, reset, rsp_tvalid && (rsp_tuser != KIND_STATUS), (rsp_tdata[RSP_FOUND_LSB] == 1'b0) && (rsp_tdata[RSP_ERR_LSB +: ERR_BITS] == ERR_OK), "event beat carries found or error")
   `SETQ_ASSERT_IMP(a_empty_next_zero, clock, reset, rsp_tvalid && rsp_tdata[RSP_EMPTY_LSB], rsp_tdata[RSP_NEXT_LSB +: TIME_BITS] == '0, "empty queue reports a next time")

endmodule

bind sorted_event_timer_queue_top setq_checker u_setq_checker (.*);
